// ===== rtl/core/deadline_monotonic_dispatcher_macros.svh =====
// Assertion macros for the dispatcher's port checks.
`ifndef DEADLINE_MONOTONIC_DISPATCHER_MACROS_SVH
`define DEADLINE_MONOTONIC_DISPATCHER_MACROS_SVH

// Checked at every edge, including while reset is held.
`define DMD_CHECK_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("dispatcher check failed");

// Checked only outside reset.
`define DMD_CHECK_RUN(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dispatcher check failed");

`endif

// ===== rtl/core/dmd_pkg.sv =====
// Shared types and constants of the deadline-monotonic dispatcher.
`default_nettype none

package dmd_pkg;

  localparam int unsigned ID_W   = 16;
  // Queue depth must stay a power of two so the pointers wrap naturally.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_BEGIN   = 2'd0,
    KIND_THREAD  = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OUT_MISS  = 2'd0,
    OUT_RUN   = 2'd1,
    OUT_SLEEP = 2'd2,
    OUT_IDLE  = 2'd3
  } outcome_e;

  // Head-of-queue status from front to back.
  typedef struct packed {
    logic  valid;
    kind_e kind;
  } item_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/deadline_monotonic_dispatcher.sv =====
// Deadline-monotonic dispatcher: front decode queue feeding the round evaluator.
// Throughput: one item per cycle unless a full result queue stalls an end item;
// a two-entry queue on each side absorbs stalls. An end item queues its result.
// Each item is evaluated by the back end against the running minima.
// Reset (async, active low) empties both queues, sets round time to zero and
// marks the soonest release and the preemption gap as none.
`default_nettype none

module deadline_monotonic_dispatcher
  import dmd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [1:0]           kind_i,
  input  wire logic [TIME_BITS-1:0] now_i,
  input  wire logic [ID_W-1:0]      thread_id_i,
  input  wire logic [TIME_BITS-1:0] arrival_time_i,
  input  wire logic [TIME_BITS-1:0] remaining_time_i,
  input  wire logic [TIME_BITS-1:0] period_i,
  input  wire logic [TIME_BITS-1:0] deadline_i,
  input  wire logic [TIME_BITS-1:0] release_time_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [1:0]                outcome_o,
  output logic [ID_W-1:0]           chosen_id_o,
  output logic [TIME_BITS-1:0]      grant_ticks_o
);

  item_ctl_t            head_ctl;
  logic                 take;
  outcome_e             outcome;
  logic [TIME_BITS-1:0] head_now;
  logic [ID_W-1:0]      head_id;
  logic [TIME_BITS-1:0] head_arr;
  logic [TIME_BITS-1:0] head_rem;
  logic [TIME_BITS-1:0] head_per;
  logic [TIME_BITS-1:0] head_dl;
  logic [TIME_BITS-1:0] head_rel;

  // request intake and decode
  dmd_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .kind_i          (kind_i),
    .now_i           (now_i),
    .thread_id_i     (thread_id_i),
    .arrival_time_i  (arrival_time_i),
    .remaining_time_i(remaining_time_i),
    .period_i        (period_i),
    .deadline_i      (deadline_i),
    .release_time_i  (release_time_i),
    .take_i          (take),
    .ctl_o           (head_ctl),
    .now_o           (head_now),
    .thread_id_o     (head_id),
    .arrival_time_o  (head_arr),
    .remaining_time_o(head_rem),
    .period_o        (head_per),
    .deadline_o      (head_dl),
    .release_time_o  (head_rel)
  );

  // round evaluation and result queue
  dmd_back #(
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (head_ctl),
    .now_i           (head_now),
    .thread_id_i     (head_id),
    .arrival_time_i  (head_arr),
    .remaining_time_i(head_rem),
    .period_i        (head_per),
    .deadline_i      (head_dl),
    .release_time_i  (head_rel),
    .take_o          (take),
    .empty_o         (empty),
    .pop_i           (pop),
    .outcome_o       (outcome),
    .chosen_id_o     (chosen_id_o),
    .grant_ticks_o   (grant_ticks_o)
  );

  assign outcome_o = outcome;

endmodule

`default_nettype wire

// ===== rtl/core/dmd_front.sv =====
// Front end: accepts requests, decodes the item kind and buffers items.
`default_nettype none

module dmd_front
  import dmd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  output logic                      full_o,
  input  wire logic [1:0]           kind_i,
  input  wire logic [TIME_BITS-1:0] now_i,
  input  wire logic [ID_W-1:0]      thread_id_i,
  input  wire logic [TIME_BITS-1:0] arrival_time_i,
  input  wire logic [TIME_BITS-1:0] remaining_time_i,
  input  wire logic [TIME_BITS-1:0] period_i,
  input  wire logic [TIME_BITS-1:0] deadline_i,
  input  wire logic [TIME_BITS-1:0] release_time_i,
  input  wire logic                 take_i,
  output item_ctl_t                 ctl_o,
  output logic [TIME_BITS-1:0]      now_o,
  output logic [ID_W-1:0]           thread_id_o,
  output logic [TIME_BITS-1:0]      arrival_time_o,
  output logic [TIME_BITS-1:0]      remaining_time_o,
  output logic [TIME_BITS-1:0]      period_o,
  output logic [TIME_BITS-1:0]      deadline_o,
  output logic [TIME_BITS-1:0]      release_time_o
);

  localparam int unsigned ENT_W = 2 + ID_W + 6 * TIME_BITS;

  logic [ENT_W-1:0]  mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push_ok;
  logic              pop_ok;
  logic [ENT_W-1:0]  ent_in;
  logic [ENT_W-1:0]  ent_out;

  // handshake
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign push_ok = push_i && !full_o;
  assign pop_ok  = take_i && (cnt_q != '0);

  assign ent_in = {kind_i, now_i, thread_id_i, arrival_time_i, remaining_time_i,
                   period_i, deadline_i, release_time_i};

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= ent_in;
    end
  end

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // head of queue, kind decoded
  assign ent_out     = mem_q[rd_ptr_q];
  assign ctl_o.valid = (cnt_q != '0);
  assign ctl_o.kind  = kind_e'(ent_out[ENT_W-1 -: 2]);
  assign {now_o, thread_id_o, arrival_time_o, remaining_time_o,
          period_o, deadline_o, release_time_o} = ent_out[ENT_W-3:0];

endmodule

`default_nettype wire

// ===== rtl/core/dmd_back.sv =====
// Back end: running minima over a round and the result queue.
`default_nettype none

module dmd_back
  import dmd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire item_ctl_t            ctl_i,
  input  wire logic [TIME_BITS-1:0] now_i,
  input  wire logic [ID_W-1:0]      thread_id_i,
  input  wire logic [TIME_BITS-1:0] arrival_time_i,
  input  wire logic [TIME_BITS-1:0] remaining_time_i,
  input  wire logic [TIME_BITS-1:0] period_i,
  input  wire logic [TIME_BITS-1:0] deadline_i,
  input  wire logic [TIME_BITS-1:0] release_time_i,
  output logic                      take_o,
  output logic                      empty_o,
  input  wire logic                 pop_i,
  output outcome_e                  outcome_o,
  output logic [ID_W-1:0]           chosen_id_o,
  output logic [TIME_BITS-1:0]      grant_ticks_o
);

  localparam int unsigned WT    = TIME_BITS + 1;
  localparam int unsigned RES_W = 2 + ID_W + TIME_BITS;
  localparam logic [WT-1:0] NONE_MARK = '1;

  // round state
  logic [TIME_BITS-1:0] round_now_q, round_now_d;
  logic                 miss_found_q, miss_found_d;
  logic [ID_W-1:0]      miss_id_q, miss_id_d;
  logic                 best_found_q, best_found_d;
  logic [ID_W-1:0]      best_id_q, best_id_d;
  logic [TIME_BITS-1:0] best_period_q, best_period_d;
  logic [TIME_BITS-1:0] best_rem_q, best_rem_d;
  logic [TIME_BITS-1:0] best_dl_q, best_dl_d;
  logic [WT-1:0]        soonest_q, soonest_d;
  logic [WT-1:0]        gap_q, gap_d;

  // result queue
  logic [RES_W-1:0]  res_q [QDEPTH];
  logic [QPTR_W-1:0] oq_wr_q, oq_rd_q;
  logic [QCNT_W-1:0] oq_cnt_q, oq_cnt_d;
  logic              oq_full;
  logic              oq_push;
  logic              oq_pop;

  logic                 outranks;
  logic                 miss_hit;
  logic                 best_hit;
  logic                 rel_hit;
  logic                 gap_hit;
  logic [WT-1:0]        arr_gap;
  logic [WT-1:0]        rem_w;
  logic [WT-1:0]        win;
  logic [TIME_BITS-1:0] ttd;
  logic [TIME_BITS-1:0] alloc_a;
  logic [TIME_BITS-1:0] alloc;
  outcome_e             res_outcome;
  logic [ID_W-1:0]      res_id;
  logic [TIME_BITS-1:0] res_time;

  // an end item waits only for room in the result queue
  assign oq_full = (oq_cnt_q == QCNT_W'(QDEPTH));
  assign take_o  = ctl_i.valid && ((ctl_i.kind != KIND_END) || !oq_full);
  assign oq_push = take_o && (ctl_i.kind == KIND_END);
  assign empty_o = (oq_cnt_q == '0);
  assign oq_pop  = pop_i && !empty_o;

  // priority compare: shorter period, then smaller ID
  assign outranks = (period_i != best_period_q) ? (period_i < best_period_q)
                                                : (thread_id_i < best_id_q);

  // thread entry checks
  assign miss_hit = (deadline_i <= round_now_q) &&
                    (!miss_found_q || (thread_id_i < miss_id_q));
  assign best_hit = (arrival_time_i <= round_now_q) && (remaining_time_i != '0) &&
                    (!best_found_q || outranks);

  // release entry checks
  assign rel_hit = (release_time_i > round_now_q) && ({1'b0, release_time_i} < soonest_q);
  assign arr_gap = {1'b0, arrival_time_i} - {1'b0, round_now_q};
  assign rem_w   = {1'b0, best_rem_q};
  assign win     = (rem_w < gap_q) ? rem_w : gap_q;
  assign gap_hit = best_found_q && (arrival_time_i > round_now_q) &&
                   (arr_gap < win) && outranks;

  // next round state
  always_comb begin
    round_now_d   = round_now_q;
    miss_found_d  = miss_found_q;
    miss_id_d     = miss_id_q;
    best_found_d  = best_found_q;
    best_id_d     = best_id_q;
    best_period_d = best_period_q;
    best_rem_d    = best_rem_q;
    best_dl_d     = best_dl_q;
    soonest_d     = soonest_q;
    gap_d         = gap_q;
    if (take_o) begin
      case (ctl_i.kind)
        KIND_BEGIN: begin
          round_now_d   = now_i;
          miss_found_d  = 1'b0;
          miss_id_d     = '0;
          best_found_d  = 1'b0;
          best_id_d     = '0;
          best_period_d = '0;
          best_rem_d    = '0;
          best_dl_d     = '0;
          soonest_d     = NONE_MARK;
          gap_d         = NONE_MARK;
        end
        KIND_THREAD: begin
          if (miss_hit) begin
            miss_found_d = 1'b1;
            miss_id_d    = thread_id_i;
          end
          if (best_hit) begin
            best_found_d  = 1'b1;
            best_id_d     = thread_id_i;
            best_period_d = period_i;
            best_rem_d    = remaining_time_i;
            best_dl_d     = deadline_i;
          end
        end
        KIND_RELEASE: begin
          if (rel_hit) begin
            soonest_d = {1'b0, release_time_i};
          end
          if (gap_hit) begin
            gap_d = arr_gap;
          end
        end
        default: begin
          // end of round leaves the state as it is
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_now_q   <= '0;
      miss_found_q  <= 1'b0;
      miss_id_q     <= '0;
      best_found_q  <= 1'b0;
      best_id_q     <= '0;
      best_period_q <= '0;
      best_rem_q    <= '0;
      best_dl_q     <= '0;
      soonest_q     <= NONE_MARK;
      gap_q         <= NONE_MARK;
    end else begin
      round_now_q   <= round_now_d;
      miss_found_q  <= miss_found_d;
      miss_id_q     <= miss_id_d;
      best_found_q  <= best_found_d;
      best_id_q     <= best_id_d;
      best_period_q <= best_period_d;
      best_rem_q    <= best_rem_d;
      best_dl_q     <= best_dl_d;
      soonest_q     <= soonest_d;
      gap_q         <= gap_d;
    end
  end

  // allocation: min of remaining, preemption gap and time to deadline
  assign ttd     = (best_dl_q > round_now_q) ? (best_dl_q - round_now_q) : '0;
  assign alloc_a = (gap_q < rem_w) ? gap_q[TIME_BITS-1:0] : best_rem_q;
  assign alloc   = (ttd < alloc_a) ? ttd : alloc_a;

  // outcome select: miss, then run, then sleep, then nothing
  always_comb begin
    if (miss_found_q) begin
      res_outcome = OUT_MISS;
      res_id      = miss_id_q;
      res_time    = '0;
    end else if (best_found_q) begin
      res_outcome = OUT_RUN;
      res_id      = best_id_q;
      res_time    = alloc;
    end else if (soonest_q != NONE_MARK) begin
      res_outcome = OUT_SLEEP;
      res_id      = '0;
      res_time    = soonest_q[TIME_BITS-1:0] - round_now_q;
    end else begin
      res_outcome = OUT_IDLE;
      res_id      = '0;
      res_time    = '0;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      res_q[oq_wr_q] <= {res_outcome, res_id, res_time};
    end
  end

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_push && !oq_pop) begin
      oq_cnt_d = oq_cnt_q + QCNT_W'(1);
    end else if (oq_pop && !oq_push) begin
      oq_cnt_d = oq_cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + QPTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + QPTR_W'(1);
      end
    end
  end

  assign outcome_o = outcome_e'(res_q[oq_rd_q][RES_W-1 -: 2]);
  assign {chosen_id_o, grant_ticks_o} = res_q[oq_rd_q][RES_W-3:0];

endmodule

`default_nettype wire

// ===== rtl/core/dmd_checker.sv =====
// Port-level checks for the dispatcher and their binding.
`default_nettype none

`include "deadline_monotonic_dispatcher_macros.svh"

module dmd_port_checks
  import dmd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 31
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 full,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire logic [1:0]           outcome_o,
  input wire logic [ID_W-1:0]      chosen_id_o,
  input wire logic [TIME_BITS-1:0] grant_ticks_o
);

  // the result queue is empty and the front queue not full on the edge after reset is seen
  `DMD_CHECK_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (empty && !full))

  // sleep and nothing-left carry no thread
  `DMD_CHECK_RUN(a_no_id, clk_i, rst_ni,
    (!empty && (outcome_o == OUT_SLEEP || outcome_o == OUT_IDLE)) |-> (chosen_id_o == '0))

  // miss and nothing-left grant no time
  `DMD_CHECK_RUN(a_no_time, clk_i, rst_ni,
    (!empty && (outcome_o == OUT_MISS || outcome_o == OUT_IDLE)) |-> (grant_ticks_o == '0))

  // a waiting result holds until taken
  `DMD_CHECK_RUN(a_hold, clk_i, rst_ni,
    (!empty && !pop) |=> (!empty && $stable(outcome_o) && $stable(chosen_id_o) &&
                          $stable(grant_ticks_o)))

endmodule

bind deadline_monotonic_dispatcher dmd_port_checks #(
  .TIME_BITS(TIME_BITS)
) u_dmd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .outcome_o       (outcome_o),
  .chosen_id_o     (chosen_id_o),
  .grant_ticks_o   (grant_ticks_o)
);

`default_nettype wire

// ===== tb/dmd_checker.sv =====
// Dispatcher checker: watches both queue sides, predicts each decision and compares.
`timescale 1ns / 100ps

module dmd_checker
  import dmd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic                 full,
  input  logic [1:0]           kind_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [ID_W-1:0]      thread_id_i,
  input  logic [TIME_BITS-1:0] arrival_time_i,
  input  logic [TIME_BITS-1:0] remaining_time_i,
  input  logic [TIME_BITS-1:0] period_i,
  input  logic [TIME_BITS-1:0] deadline_i,
  input  logic [TIME_BITS-1:0] release_time_i,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [1:0]           outcome_o,
  input  logic [ID_W-1:0]      chosen_id_o,
  input  logic [TIME_BITS-1:0] grant_ticks_o,
  output int unsigned          mismatch_count,
  output int unsigned          decisions_waiting
);

  typedef logic [TIME_BITS-1:0] tick_t;
  typedef logic [TIME_BITS:0]   wide_tick_t;
  typedef logic [ID_W-1:0]      tid_t;

  typedef struct {
    outcome_e outcome;
    tid_t     chosen;
    tick_t    alloc;
  } decision_t;

  // "none" is one bit wider than any tick
  localparam wide_tick_t NO_TICK = '1;

  // Running round state of the model
  tick_t      round_now;
  bit         missed_seen;
  tid_t       missed_tid;
  bit         best_seen;
  tid_t       best_tid;
  tick_t      best_per;
  tick_t      best_rem;
  tick_t      best_dl;
  wide_tick_t soonest_wake;
  wide_tick_t preempt_limit;

  decision_t  expected_decisions[$];

  function automatic bit ranks_above(tick_t pa, tid_t ia, tick_t pb, tid_t ib);
    return (pa != pb) ? (pa < pb) : (ia < ib);
  endfunction

  task automatic clear_round();
    missed_seen   = 1'b0;
    missed_tid    = '0;
    best_seen     = 1'b0;
    best_tid      = '0;
    best_per      = '0;
    best_rem      = '0;
    best_dl       = '0;
    soonest_wake  = NO_TICK;
    preempt_limit = NO_TICK;
  endtask

  // Fold one accepted request into the round state; an end request yields a decision.
  task automatic track_request(kind_e k, tick_t t_now, tid_t tid, tick_t arr, tick_t rem,
                               tick_t per, tick_t dl, tick_t rel);
    wide_tick_t gap;
    wide_tick_t window;
    wide_tick_t grant;
    wide_tick_t to_deadline;
    decision_t  d;
    case (k)
      KIND_BEGIN: begin
        round_now = t_now;
        clear_round();
      end
      KIND_THREAD: begin
        if (dl <= round_now && (!missed_seen || tid < missed_tid)) begin
          missed_seen = 1'b1;
          missed_tid  = tid;
        end
        if (arr <= round_now && rem != 0 &&
            (!best_seen || ranks_above(per, tid, best_per, best_tid))) begin
          best_seen = 1'b1;
          best_tid  = tid;
          best_per  = per;
          best_rem  = rem;
          best_dl   = dl;
        end
      end
      KIND_RELEASE: begin
        if (rel > round_now && {1'b0, rel} < soonest_wake) soonest_wake = {1'b0, rel};
        // a higher-priority arrival inside the current window shortens the grant
        if (best_seen && arr > round_now) begin
          gap    = {1'b0, arr} - {1'b0, round_now};
          window = ({1'b0, best_rem} < preempt_limit) ? {1'b0, best_rem} : preempt_limit;
          if (gap < window && ranks_above(per, tid, best_per, best_tid))
            preempt_limit = gap;
        end
      end
      default: begin
        if (missed_seen) begin
          d.outcome = OUT_MISS;
          d.chosen  = missed_tid;
          d.alloc   = '0;
        end else if (best_seen) begin
          grant       = {1'b0, best_rem};
          to_deadline = (best_dl > round_now) ? {1'b0, best_dl} - {1'b0, round_now} : '0;
          if (preempt_limit < grant) grant = preempt_limit;
          if (to_deadline < grant) grant = to_deadline;
          d.outcome = OUT_RUN;
          d.chosen  = best_tid;
          d.alloc   = grant[TIME_BITS-1:0];
        end else if (soonest_wake != NO_TICK) begin
          grant     = soonest_wake - {1'b0, round_now};
          d.outcome = OUT_SLEEP;
          d.chosen  = '0;
          d.alloc   = grant[TIME_BITS-1:0];
        end else begin
          d.outcome = OUT_IDLE;
          d.chosen  = '0;
          d.alloc   = '0;
        end
        expected_decisions.push_back(d);
      end
    endcase
  endtask

  // Compare popped decisions first, then take in the new request.
  always @(posedge clk_i) begin
    decision_t want;
    if (!rst_ni) begin
      round_now = '0;
      clear_round();
      expected_decisions.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_decisions.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          $display("%0t: decision with none expected: outcome %0d id %0d grant %0d",
                   $time, outcome_o, chosen_id_o, grant_ticks_o);
        end else begin
          want = expected_decisions.pop_front();
          if (outcome_o !== want.outcome || chosen_id_o !== want.chosen ||
              grant_ticks_o !== want.alloc) begin
            mismatch_count <= mismatch_count + 1;
            if (outcome_o !== want.outcome)
              $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome_o);
            if (chosen_id_o !== want.chosen)
              $display("%0t: chosen_id expected %0d actual %0d", $time, want.chosen,
                       chosen_id_o);
            if (grant_ticks_o !== want.alloc)
              $display("%0t: grant_ticks expected %0d actual %0d", $time, want.alloc,
                       grant_ticks_o);
          end
        end
      end
      if (push && !full)
        track_request(kind_e'(kind_i), now_i, thread_id_i, arrival_time_i, remaining_time_i,
                      period_i, deadline_i, release_time_i);
    end
    decisions_waiting <= expected_decisions.size();
  end

endmodule

// ===== tb/tb_deadline_monotonic_dispatcher.sv =====
// Top of the dispatcher testbench: clock, reset, request stimulus, pop pacing and verdict.
`timescale 1ns / 100ps

module tb_deadline_monotonic_dispatcher;
  import dmd_pkg::*;

  localparam int unsigned TIME_BITS   = 31;
  localparam longint      TICK_LIMIT  = (64'sd1 <<< TIME_BITS) - 1;
  localparam int unsigned ITEM_TARGET = 500;
  localparam int unsigned CALM_AFTER  = 440;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic [TIME_BITS-1:0] tick_t;
  typedef logic [ID_W-1:0]      tid_t;

  localparam tick_t TICK_MAX = '1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 pop = 1'b0;
  logic [1:0]           kind_i = KIND_BEGIN;
  tick_t                now_i = '0;
  tid_t                 thread_id_i = '0;
  tick_t                arrival_time_i = '0;
  tick_t                remaining_time_i = '0;
  tick_t                period_i = '0;
  tick_t                deadline_i = '0;
  tick_t                release_time_i = '0;
  logic                 full;
  logic                 empty;
  logic [1:0]           outcome_o;
  tid_t                 chosen_id_o;
  tick_t                grant_ticks_o;

  int unsigned mismatch_count;
  int unsigned decisions_waiting;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned push_idle_rate = 0;
  bit          calm = 1'b0;

  deadline_monotonic_dispatcher #(.TIME_BITS(TIME_BITS)) dut (
    .clk_i, .rst_ni, .push, .full, .kind_i, .now_i, .thread_id_i, .arrival_time_i,
    .remaining_time_i, .period_i, .deadline_i, .release_time_i, .empty, .pop,
    .outcome_o, .chosen_id_o, .grant_ticks_o
  );

  dmd_checker #(.TIME_BITS(TIME_BITS)) checker_inst (
    .clk_i, .rst_ni, .push, .full, .kind_i, .now_i, .thread_id_i, .arrival_time_i,
    .remaining_time_i, .period_i, .deadline_i, .release_time_i, .empty, .pop,
    .outcome_o, .chosen_id_o, .grant_ticks_o, .mismatch_count, .decisions_waiting
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Pop side: stall bursts at a randomly chosen rate, redrawn for each span
  initial begin
    int unsigned hold;
    int unsigned span;
    int unsigned pop_idle_rate;
    hold = 0;
    span = 0;
    pop_idle_rate = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        span = 64;
        case ($urandom_range(0, 2))
          0:       pop_idle_rate = 0;
          1:       pop_idle_rate = 3;
          default: pop_idle_rate = 12;
        endcase
      end
      span--;
      if (hold == 0 && !calm && pop_idle_rate != 0 &&
          $urandom_range(0, pop_idle_rate) == 0)
        hold = $urandom_range(1, 14);
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic tick_t any_tick();
    return tick_t'($urandom);
  endfunction

  function automatic tick_t clamp_tick(longint v);
    if (v < 0) return '0;
    if (v > TICK_LIMIT) return TICK_MAX;
    return tick_t'(v);
  endfunction

  // Time near the round's now, either side, or sometimes any tick
  function automatic tick_t around(tick_t base);
    longint v;
    case ($urandom_range(0, 3))
      0:       v = longint'(any_tick());
      1:       v = longint'(base) + int'($urandom_range(0, 8)) - 4;
      2:       v = longint'(base) + int'($urandom_range(0, 400)) - 200;
      default: v = longint'(base) + int'($urandom_range(0, 4000)) - 1000;
    endcase
    return clamp_tick(v);
  endfunction

  // Deadline: mostly in the future so misses stay a minority
  function automatic tick_t pick_deadline(tick_t base);
    if ($urandom_range(0, 5) == 0) return around(base);
    return clamp_tick(longint'(base) + int'($urandom_range(1, 2000)));
  endfunction

  function automatic tick_t pick_now();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TICK_MAX;
      2:       return tick_t'($urandom_range(0, 5000));
      default: return any_tick();
    endcase
  endfunction

  function automatic tid_t pick_tid();
    if ($urandom_range(0, 3) == 0) return tid_t'($urandom);
    return tid_t'($urandom_range(0, 7));
  endfunction

  function automatic tick_t pick_period();
    tick_t p;
    case ($urandom_range(0, 7))
      0:       p = any_tick();
      1:       p = TICK_MAX;
      default: p = tick_t'($urandom_range(1, 8));
    endcase
    return (p == 0) ? tick_t'(1) : p;
  endfunction

  function automatic tick_t pick_remaining();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return any_tick();
      default: return tick_t'($urandom_range(1, 300));
    endcase
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_request(input kind_e k, input tick_t t_now, input tid_t tid,
                              input tick_t arr, input tick_t rem, input tick_t per,
                              input tick_t dl, input tick_t rel);
    int unsigned gap;
    gap = 0;
    if (!calm && push_idle_rate != 0 && $urandom_range(0, push_idle_rate) == 0)
      gap = $urandom_range(1, 14);
    @(negedge clk_i);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push             <= 1'b1;
    kind_i           <= k;
    now_i            <= t_now;
    thread_id_i      <= tid;
    arrival_time_i   <= arr;
    remaining_time_i <= rem;
    period_i         <= per;
    deadline_i       <= dl;
    release_time_i   <= rel;
    do @(posedge clk_i); while (full !== 1'b0);
    sent++;
  endtask

  initial begin
    tick_t       base;
    int unsigned n_threads;
    int unsigned n_entries;
    int unsigned n_early;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // End with no round open: reset state gives nothing left
    send_request(KIND_END, 0, 0, 0, 0, 0, 0, 0);
    // Release at the top tick, then a repeated end
    send_request(KIND_BEGIN, 100, 0, 0, 0, 0, 0, 0);
    send_request(KIND_RELEASE, 0, 4, 50, 0, 2, 0, TICK_MAX);
    send_request(KIND_END, 0, 0, 0, 0, 0, 0, 0);
    send_request(KIND_END, 0, 0, 0, 0, 0, 0, 0);
    // Release before any thread, equal-rank future thread, then a real preemption
    send_request(KIND_BEGIN, 1000, 0, 0, 0, 0, 0, 0);
    send_request(KIND_RELEASE, 0, 1, 1005, 0, 1, 0, 1005);
    send_request(KIND_THREAD, 0, 5, 900, 50, 10, 2000, 0);
    send_request(KIND_RELEASE, 0, 5, 1010, 0, 10, 0, 1010);
    send_request(KIND_RELEASE, 0, 9, 1020, 0, 3, 0, 1020);
    send_request(KIND_END, 0, 0, 0, 0, 0, 0, 0);
    // Two misses and a runnable thread: smallest missed ID wins
    send_request(KIND_BEGIN, 500, 0, 0, 0, 0, 0, 0);
    send_request(KIND_THREAD, 0, 7, 0, 10, 5, 400, 0);
    send_request(KIND_THREAD, 0, 3, 0, 10, 5, 500, 0);
    send_request(KIND_THREAD, 0, 1, 0, 10, 1, 900, 0);
    send_request(KIND_END, 0, 0, 0, 0, 0, 0, 0);
    // Largest thread fields everywhere but the arrival time
    send_request(KIND_BEGIN, 0, 0, 0, 0, 0, 0, 0);
    send_request(KIND_THREAD, 0, '1, 0, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX);
    send_request(KIND_END, 0, 0, 0, 0, 0, 0, 0);
    // Latest now: the deadline has passed though the thread has no work left
    send_request(KIND_BEGIN, TICK_MAX, 0, 0, 0, 0, 0, 0);
    send_request(KIND_THREAD, 0, 0, 0, 0, 1, TICK_MAX, 0);
    send_request(KIND_END, 0, 0, 0, 0, 0, 0, 0);

    // Random rounds, with some stray requests mixed in
    while (sent < ITEM_TARGET) begin
      if (sent >= CALM_AFTER) calm = 1'b1;
      case ($urandom_range(0, 3))
        0:       push_idle_rate = 0;
        1:       push_idle_rate = 2;
        default: push_idle_rate = 10;
      endcase
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4))
          send_request(kind_e'($urandom_range(0, 3)), any_tick(), tid_t'($urandom),
                       any_tick(), any_tick(), any_tick(), any_tick(), any_tick());
      end else begin
        base      = pick_now();
        n_threads = $urandom_range(0, 6);
        n_entries = $urandom_range(0, 4);
        n_early   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_entries) : 0;
        send_request(KIND_BEGIN, base, tid_t'($urandom), any_tick(), any_tick(), any_tick(),
                     any_tick(), any_tick());
        repeat (n_early)
          send_request(KIND_RELEASE, any_tick(), pick_tid(), around(base), any_tick(),
                       pick_period(), any_tick(), around(base));
        repeat (n_threads)
          send_request(KIND_THREAD, any_tick(), pick_tid(), around(base), pick_remaining(),
                       pick_period(), pick_deadline(base), any_tick());
        repeat (n_entries - n_early)
          send_request(KIND_RELEASE, any_tick(), pick_tid(), around(base), any_tick(),
                       pick_period(), any_tick(), around(base));
        send_request(KIND_END, any_tick(), tid_t'($urandom), any_tick(), any_tick(),
                     any_tick(), any_tick(), any_tick());
        if ($urandom_range(0, 9) == 0)
          send_request(KIND_END, any_tick(), tid_t'($urandom), any_tick(), any_tick(),
                       any_tick(), any_tick(), any_tick());
      end
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (decisions_waiting != 0) @(negedge clk_i);
    // let any stray late decision show up
    repeat (16) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dmd_pkg.sv
rtl/core/dmd_front.sv
rtl/core/dmd_back.sv
rtl/core/deadline_monotonic_dispatcher.sv
rtl/core/dmd_checker.sv
tb/dmd_checker.sv
tb/tb_deadline_monotonic_dispatcher.sv
